// ===== src/irc_pkg.sv =====
// Shared types, codes and result helpers for the infix-to-RPN converter.
`default_nettype none

package irc_pkg;

    // Default sizing of the operator stack and the constant index space
    localparam int DEF_STACK_DEPTH = 32;
    localparam int DEF_INDEX_LIMIT = 1024;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Fixed field widths
    localparam int MODE_W  = 3;
    localparam int INDEX_W = 10;
    localparam int POS_W   = 16;

    // Incoming token modes
    typedef enum logic [2:0] {
        MODE_VAR    = 3'd0,
        MODE_FUNC   = 3'd1,
        MODE_NUM    = 3'd2,
        MODE_BINOP  = 3'd3,
        MODE_LPAREN = 3'd4,
        MODE_RPAREN = 3'd5,
        MODE_END    = 3'd6
    } t_mode;

    // Classified command kinds handed from front to back
    typedef enum logic [2:0] {
        CMD_VAR,
        CMD_FUNC,
        CMD_NUM,
        CMD_BINOP,
        CMD_LPAREN,
        CMD_RPAREN,
        CMD_END
    } t_cmd_kind;

    // Kinds of entries waiting on the operator stack
    typedef enum logic [1:0] {
        ENT_LPAREN = 2'd0,
        ENT_BINARY = 2'd1,
        ENT_FUNC   = 2'd2
    } t_ent_kind;

    // RPN token kinds
    typedef enum logic [1:0] {
        RPN_VAR   = 2'd0,
        RPN_CONST = 2'd1,
        RPN_UNARY = 2'd2,
        RPN_BINARY = 2'd3
    } t_rpn_kind;

    // RPN operators
    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_SIN  = 3'd4,
        OP_SQRT = 3'd5
    } t_rpn_op;

    // Function name codes on the input
    typedef enum logic [1:0] {
        FN_SIN  = 2'd0,
        FN_SQRT = 2'd1
    } t_func;

    // Error codes
    typedef enum logic [3:0] {
        ERR_NONE            = 4'd0,
        ERR_OP_BEFORE_IDENT = 4'd1,
        ERR_OP_BEFORE_NUM   = 4'd2,
        ERR_UNEXP_OP        = 4'd3,
        ERR_UNEXP_RPAREN    = 4'd4,
        ERR_MISMATCH_RPAREN = 4'd5,
        ERR_EARLY_END       = 4'd6,
        ERR_MISMATCH_LPAREN = 4'd7,
        ERR_UNKNOWN_FUNC    = 4'd8,
        ERR_STACK_OVERFLOW  = 4'd9,
        ERR_EMPTY_OR_INDEX  = 4'd10
    } t_err;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_OP,
        S_POP_RP,
        S_RP_FUNC,
        S_POP_END
    } t_back_state;

    // Classified item as it sits in the queue
    typedef struct packed {
        t_cmd_kind          kind;
        t_rpn_op            op;
        logic               high_rank;
        logic               bad_func;
        logic [INDEX_W-1:0] var_index;
        logic [POS_W-1:0]   position;
    } t_cmd;

    // Operator stack entry
    typedef struct packed {
        t_ent_kind        kind;
        t_rpn_op          op;
        logic [POS_W-1:0] pos;
    } t_entry;

    // One result item
    typedef struct packed {
        logic               has_token;
        t_rpn_kind          rpn_kind;
        logic [INDEX_W-1:0] rpn_index;
        t_rpn_op            rpn_op;
        t_err               error_code;
        logic [POS_W-1:0]   error_position;
        logic               finished;
    } t_result;

    // Result produced by the back end in one cycle
    typedef struct packed {
        logic    valid;
        logic    step_end;
        t_result result;
    } t_gen;

    // Multiply and divide bind tighter than add and subtract
    function automatic logic is_high_rank(t_rpn_op op);
        return (op == OP_MUL) || (op == OP_DIV);
    endfunction

    function automatic t_result token_var(logic [INDEX_W-1:0] idx);
        t_result r;
        r           = '0;
        r.has_token = 1'b1;
        r.rpn_kind  = RPN_VAR;
        r.rpn_index = idx;
        return r;
    endfunction

    function automatic t_result token_const(logic [INDEX_W-1:0] idx);
        t_result r;
        r           = '0;
        r.has_token = 1'b1;
        r.rpn_kind  = RPN_CONST;
        r.rpn_index = idx;
        return r;
    endfunction

    // Popped stack entry: functions are unary, the rest binary
    function automatic t_result token_entry(t_entry e);
        t_result r;
        r           = '0;
        r.has_token = 1'b1;
        r.rpn_kind  = (e.kind == ENT_FUNC) ? RPN_UNARY : RPN_BINARY;
        r.rpn_op    = e.op;
        return r;
    endfunction

    function automatic t_result status_err(t_err code, logic [POS_W-1:0] pos);
        t_result r;
        r                = '0;
        r.error_code     = code;
        r.error_position = pos;
        return r;
    endfunction

    function automatic t_result status_done();
        t_result r;
        r          = '0;
        r.finished = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/irc_front.sv =====
// Front end: accepts tokens, drops invalid modes and classifies the rest.
`default_nettype none

module irc_front import irc_pkg::*; (
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [MODE_W-1:0]   i_mode,
    input  wire logic [1:0]          i_op_code,
    input  wire logic [1:0]          i_func_code,
    input  wire logic [INDEX_W-1:0]  i_var_index,
    input  wire logic [POS_W-1:0]    i_position,
    input  wire logic                i_full,
    output logic                     o_push,
    output t_cmd                     o_cmd
);

    logic w_known;

    // Hold the input while the queue is full
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full && w_known;

    // Classify the token
    always_comb begin
        w_known          = 1'b1;
        o_cmd            = '0;
        o_cmd.var_index  = i_var_index;
        o_cmd.position   = i_position;
        o_cmd.op         = t_rpn_op'({1'b0, i_op_code});
        o_cmd.high_rank  = is_high_rank(t_rpn_op'({1'b0, i_op_code}));
        o_cmd.bad_func   = (i_func_code != FN_SIN) && (i_func_code != FN_SQRT);
        o_cmd.kind       = CMD_VAR;
        unique case (t_mode'(i_mode))
            MODE_VAR:    o_cmd.kind = CMD_VAR;
            MODE_FUNC: begin
                o_cmd.kind = CMD_FUNC;
                o_cmd.op   = (i_func_code == FN_SIN) ? OP_SIN : OP_SQRT;
            end
            MODE_NUM:    o_cmd.kind = CMD_NUM;
            MODE_BINOP:  o_cmd.kind = CMD_BINOP;
            MODE_LPAREN: o_cmd.kind = CMD_LPAREN;
            MODE_RPAREN: o_cmd.kind = CMD_RPAREN;
            MODE_END:    o_cmd.kind = CMD_END;
            // drop unused mode codes
            default:     w_known = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/irc_queue.sv =====
// Short queue of classified items between front and back end.
`default_nettype none

module irc_queue import irc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_data,
    input  wire logic i_pop
);

    localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wr, r_rd, n_wr, n_rd;
    logic [QC_W-1:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == QC_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rd];

    // Advance pointers and fill count
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QA_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QA_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/irc_back.sv =====
// Back end: shunting-yard sequencer with the operator stack memory.
`default_nettype none

module irc_back import irc_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int INDEX_LIMIT = DEF_INDEX_LIMIT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_pop,
    output t_gen      o_gen
);

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int CONST_W = $clog2(INDEX_LIMIT + 1);

    t_back_state           r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_expect, n_expect;
    logic [CONST_W-1:0]    r_const, n_const;
    logic                  r_seen, n_seen;
    t_cmd                  r_cmd, n_cmd;

    t_entry                r_stack [STACK_DEPTH];
    t_entry                r_top;

    logic                  w_we;
    t_entry                w_wdata;
    logic [CNT_W-1:0]      w_dec;
    logic [ADDR_W-1:0]     w_raddr;
    logic                  w_full, w_empty;
    logic                  w_push;
    t_entry                w_push_entry;
    logic                  w_fail;
    t_err                  w_fail_code;
    logic [POS_W-1:0]      w_fail_pos;
    logic                  w_clear;
    logic [CONST_W+INDEX_W-1:0] w_const_ext;

    assign w_full      = (r_count >= CNT_W'(STACK_DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_const_ext = {{INDEX_W{1'b0}}, r_const};

    // Next state and outputs
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_expect     = r_expect;
        n_const      = r_const;
        n_seen       = r_seen;
        n_cmd        = r_cmd;
        o_pop        = 1'b0;
        o_gen        = '0;
        w_we         = 1'b0;
        w_wdata      = r_top;
        w_push       = 1'b0;
        w_push_entry = r_top;
        w_fail       = 1'b0;
        w_fail_code  = ERR_NONE;
        w_fail_pos   = r_cmd.position;
        w_clear      = 1'b0;

        if (i_adv) begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        o_pop = 1'b1;
                        n_cmd = i_cmd;
                        if (i_cmd.kind != CMD_END) begin
                            n_seen = 1'b1;
                        end
                        w_fail_pos = i_cmd.position;
                        unique case (i_cmd.kind)
                            CMD_VAR: begin
                                if (!r_expect) begin
                                    w_fail      = 1'b1;
                                    w_fail_code = ERR_OP_BEFORE_IDENT;
                                end else begin
                                    o_gen.valid    = 1'b1;
                                    o_gen.step_end = 1'b1;
                                    o_gen.result   = token_var(i_cmd.var_index);
                                    n_expect       = 1'b0;
                                end
                            end
                            CMD_FUNC: begin
                                if (i_cmd.bad_func) begin
                                    w_fail      = 1'b1;
                                    w_fail_code = ERR_UNKNOWN_FUNC;
                                end else begin
                                    w_push       = 1'b1;
                                    w_push_entry = '{ENT_FUNC, i_cmd.op, i_cmd.position};
                                end
                            end
                            CMD_NUM: begin
                                if (!r_expect) begin
                                    w_fail      = 1'b1;
                                    w_fail_code = ERR_OP_BEFORE_NUM;
                                end else if (r_const >= CONST_W'(INDEX_LIMIT)) begin
                                    w_fail      = 1'b1;
                                    w_fail_code = ERR_EMPTY_OR_INDEX;
                                end else begin
                                    o_gen.valid    = 1'b1;
                                    o_gen.step_end = 1'b1;
                                    o_gen.result   = token_const(w_const_ext[INDEX_W-1:0]);
                                    n_const        = r_const + CONST_W'(1);
                                    n_expect       = 1'b0;
                                end
                            end
                            CMD_BINOP: begin
                                if (r_expect) begin
                                    w_fail      = 1'b1;
                                    w_fail_code = ERR_UNEXP_OP;
                                end else begin
                                    n_state = S_POP_OP;
                                end
                            end
                            CMD_LPAREN: begin
                                w_push       = 1'b1;
                                w_push_entry = '{ENT_LPAREN, OP_ADD, i_cmd.position};
                            end
                            CMD_RPAREN: begin
                                if (r_expect) begin
                                    w_fail      = 1'b1;
                                    w_fail_code = ERR_UNEXP_RPAREN;
                                end else begin
                                    n_state = S_POP_RP;
                                end
                            end
                            CMD_END: begin
                                if (!r_seen) begin
                                    w_fail      = 1'b1;
                                    w_fail_code = ERR_EMPTY_OR_INDEX;
                                end else if (r_expect) begin
                                    w_fail      = 1'b1;
                                    w_fail_code = ERR_EARLY_END;
                                end else begin
                                    n_state = S_POP_END;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // Pop waiting operators that bind at least as tight, then push
                S_POP_OP: begin
                    if (!w_empty && (r_top.kind != ENT_LPAREN) &&
                        !((r_top.kind == ENT_BINARY) && !is_high_rank(r_top.op) &&
                          r_cmd.high_rank)) begin
                        o_gen.valid  = 1'b1;
                        o_gen.result = token_entry(r_top);
                        n_count      = r_count - CNT_W'(1);
                    end else begin
                        w_push       = 1'b1;
                        w_push_entry = '{ENT_BINARY, r_cmd.op, r_cmd.position};
                        n_state      = S_IDLE;
                    end
                end

                // Pop down to the matching '('
                S_POP_RP: begin
                    if (w_empty) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_MISMATCH_RPAREN;
                    end else if (r_top.kind == ENT_LPAREN) begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_RP_FUNC;
                    end else begin
                        o_gen.valid  = 1'b1;
                        o_gen.result = token_entry(r_top);
                        n_count      = r_count - CNT_W'(1);
                    end
                end

                // Emit a function waiting just below the '('
                S_RP_FUNC: begin
                    if (!w_empty && (r_top.kind == ENT_FUNC)) begin
                        o_gen.valid  = 1'b1;
                        o_gen.result = token_entry(r_top);
                        n_count      = r_count - CNT_W'(1);
                    end
                    o_gen.step_end = 1'b1;
                    n_expect       = 1'b0;
                    n_state        = S_IDLE;
                end

                // Drain the stack at end of expression
                S_POP_END: begin
                    if (w_empty) begin
                        o_gen.valid    = 1'b1;
                        o_gen.step_end = 1'b1;
                        o_gen.result   = status_done();
                        w_clear        = 1'b1;
                    end else if (r_top.kind == ENT_LPAREN) begin
                        w_fail      = 1'b1;
                        w_fail_code = ERR_MISMATCH_LPAREN;
                        w_fail_pos  = r_top.pos;
                    end else begin
                        o_gen.valid  = 1'b1;
                        o_gen.result = token_entry(r_top);
                        n_count      = r_count - CNT_W'(1);
                    end
                end

                default: n_state = S_IDLE;
            endcase

            // Push onto the stack, or report overflow
            if (w_push) begin
                if (w_full) begin
                    w_fail      = 1'b1;
                    w_fail_code = ERR_STACK_OVERFLOW;
                    w_fail_pos  = w_push_entry.pos;
                end else begin
                    w_we           = 1'b1;
                    w_wdata        = w_push_entry;
                    n_count        = r_count + CNT_W'(1);
                    n_expect       = 1'b1;
                    o_gen.step_end = 1'b1;
                end
            end

            // Report an error and restart
            if (w_fail) begin
                o_gen.valid    = 1'b1;
                o_gen.step_end = 1'b1;
                o_gen.result   = status_err(w_fail_code, w_fail_pos);
                w_clear        = 1'b1;
            end

            if (w_clear) begin
                n_state  = S_IDLE;
                n_count  = '0;
                n_expect = 1'b1;
                n_const  = '0;
                n_seen   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_expect <= 1'b1;
            r_const  <= '0;
            r_seen   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_expect <= n_expect;
            r_const  <= n_const;
            r_seen   <= n_seen;
        end
    end

    // Hold the current command for the pop loops
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    // Stack memory; read data always tracks the entry below the next count
    assign w_dec   = n_count - CNT_W'(1);
    assign w_raddr = w_dec[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_stack[r_count[ADDR_W-1:0]] <= w_wdata;
        end
        if (w_we && (r_count[ADDR_W-1:0] == w_raddr)) begin
            r_top <= w_wdata;
        end else begin
            r_top <= r_stack[w_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/irc_out.sv =====
// Output stage: holds one result until the next shows whether it is the last.
`default_nettype none

module irc_out import irc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_gen i_gen,
    output logic      o_adv,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_result   o_result,
    output logic      o_last
);

    logic    r_p_valid, n_p_valid;
    logic    r_p_last, n_p_last;
    t_result r_p, n_p;
    logic    r_o_valid, n_o_valid;
    logic    r_o_last, n_o_last;
    t_result r_o, n_o;
    logic    w_move;

    // Advance whenever the output register is free or being taken
    assign o_adv    = !r_o_valid || !i_stall;
    assign o_valid  = r_o_valid;
    assign o_result = r_o;
    assign o_last   = r_o_last;

    // Release the held result once its successor or its step end is known
    assign w_move = r_p_valid && (r_p_last || i_gen.valid || i_gen.step_end);

    always_comb begin
        n_p_valid = r_p_valid;
        n_p_last  = r_p_last;
        n_p       = r_p;
        n_o_valid = r_o_valid;
        n_o_last  = r_o_last;
        n_o       = r_o;
        if (o_adv) begin
            n_o_valid = w_move;
            if (w_move) begin
                n_o      = r_p;
                n_o_last = r_p_last || (i_gen.step_end && !i_gen.valid);
            end
            if (i_gen.valid) begin
                n_p_valid = 1'b1;
                n_p       = i_gen.result;
                n_p_last  = i_gen.step_end;
            end else if (w_move) begin
                n_p_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_p_valid <= n_p_valid;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_last <= n_p_last;
        r_p      <= n_p;
        r_o_last <= n_o_last;
        r_o      <= n_o;
    end

endmodule

`default_nettype wire

// ===== src/infix_to_rpn_converter.sv =====
// Top level of the infix-to-RPN (shunting-yard) token converter.
//
// Converts lexed infix tokens, one per input item, into RPN result items.
// The front end takes one item per cycle into a two-entry queue while the
// queue is not full. The back end handles a variable, number, function name
// or '(' directly in its idle state. A binary operator, ')' or end is started
// in the idle state, then pops entries off the operator stack (for ')' down
// to and including the '(') and closes by pushing the operator, checking for
// a function below the '(' or emitting the end status; a syntax error found
// at the start ends the item there. Cost follows the stack pops. The stack
// sits in a memory whose registered read port always holds the top entry.
// Each result passes a one-item hold stage, which marks the final result of
// an item, then the output register. Modes outside 0 to 6 are accepted and
// dropped. On an error or a successful end the block emits a status result
// and restarts.
`default_nettype none

module infix_to_rpn_converter import irc_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int INDEX_LIMIT = DEF_INDEX_LIMIT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [MODE_W-1:0]  i_mode,
    input  wire logic [1:0]         i_op_code,
    input  wire logic [1:0]         i_func_code,
    input  wire logic [INDEX_W-1:0] i_var_index,
    input  wire logic [POS_W-1:0]   i_position,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_has_token,
    output logic [1:0]              o_rpn_kind,
    output logic [INDEX_W-1:0]      o_rpn_index,
    output logic [2:0]              o_rpn_op,
    output logic [3:0]              o_error_code,
    output logic [POS_W-1:0]        o_error_position,
    output logic                    o_finished,
    output logic                    o_last_result
);

    logic    w_full, w_push, w_q_valid, w_pop, w_adv;
    t_cmd    w_cmd_in, w_cmd_out;
    t_gen    w_gen;
    t_result w_result;

    irc_front u_front (
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_op_code   (i_op_code),
        .i_func_code (i_func_code),
        .i_var_index (i_var_index),
        .i_position  (i_position),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in)
    );

    irc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_cmd_out),
        .i_pop   (w_pop)
    );

    irc_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .INDEX_LIMIT (INDEX_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_gen       (w_gen)
    );

    irc_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gen    (w_gen),
        .o_adv    (w_adv),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (w_result),
        .o_last   (o_last_result)
    );

    // Break the result out onto its ports
    assign o_has_token      = w_result.has_token;
    assign o_rpn_kind       = w_result.rpn_kind;
    assign o_rpn_index      = w_result.rpn_index;
    assign o_rpn_op         = w_result.rpn_op;
    assign o_error_code     = w_result.error_code;
    assign o_error_position = w_result.error_position;
    assign o_finished       = w_result.finished;

endmodule

`default_nettype wire
